>>> rtl/core/scissor_rect_viewport_remap_defines.svh
// Assertion macros shared by the remap RTL.
`ifndef SCISSOR_RECT_VIEWPORT_REMAP_DEFINES_SVH
`define SCISSOR_RECT_VIEWPORT_REMAP_DEFINES_SVH

// Antecedent implies consequent on the same edge.
`define SRVR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srvr: implication check failed");

// Condition must never hold.
`define SRVR_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("srvr: forbidden condition seen");

`endif

>>> rtl/core/srvr_pkg.sv
package srvr_pkg;

    // Restoring divider: 36 quotient bits, two bits per stage.
    localparam int DIV_BITS   = 36;
    localparam int DIV_STAGES = DIV_BITS / 2;
    // Edge unit: multiply, add, load, divider stages, edge resolve.
    localparam int EDGE_LAT   = DIV_STAGES + 4;

    localparam logic [DIV_BITS-1:0] EDGE_LIMIT = 36'h4_0000_0000;
    localparam logic signed [37:0]  I32_MAX    = 38'sd2147483647;
    localparam logic signed [37:0]  I32_MIN    = -38'sd2147483648;

    typedef struct packed {
        logic signed [31:0] scissor_x;
        logic signed [31:0] scissor_y;
        logic signed [31:0] scissor_w;
        logic signed [31:0] scissor_h;
        logic signed [31:0] src_view_x;
        logic signed [31:0] src_view_y;
        logic signed [31:0] src_view_w;
        logic signed [31:0] src_view_h;
        logic signed [31:0] cap_view_x;
        logic signed [31:0] cap_view_y;
        logic signed [31:0] cap_view_w;
        logic signed [31:0] cap_view_h;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_w;
        logic signed [31:0] out_h;
        logic               accepted;
        logic               changed;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sw;
        logic signed [31:0] sh;
        logic               pre_ok;
    } meta_t;

endpackage

>>> rtl/core/srvr_edge_map.sv
`include "scissor_rect_viewport_remap_defines.svh"

module srvr_edge_map
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic signed [31:0] cv,
    input  logic        [32:0] mag,
    input  logic               neg,
    input  logic        [30:0] cw,
    input  logic        [30:0] sw,
    output logic signed [37:0] fl,
    output logic signed [37:0] ce,
    output logic               ok
);

    localparam int N = srvr_pkg::DIV_STAGES;

    // multiply stage
    logic        [62:0] mul_reg;
    logic               hi_reg;
    logic        [30:0] cw1_reg;
    logic        [30:0] sw1_reg;
    logic signed [31:0] cv1_reg;
    logic               neg1_reg;

    // add stage
    logic        [63:0] prod_reg;
    logic        [30:0] sw2_reg;
    logic signed [31:0] cv2_reg;
    logic               neg2_reg;

    // divider stages
    logic        [30:0] rem_reg [0:N];
    logic        [35:0] low_reg [0:N];
    logic        [35:0] quo_reg [0:N];
    logic               ovf_reg [0:N];
    logic        [30:0] swp_reg [0:N];
    logic signed [31:0] cvp_reg [0:N];
    logic               negp_reg[0:N];

    logic signed [37:0] fl_reg;
    logic signed [37:0] ce_reg;
    logic               ok_reg;

    logic        [63:0] prod_next;
    logic signed [37:0] fl_next;
    logic signed [37:0] ce_next;
    logic               ok_next;
    logic               rnz;
    logic               qbig;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_reg  <= 63'(mag[31:0]) * 63'(cw);
            hi_reg   <= mag[32];
            cw1_reg  <= cw;
            sw1_reg  <= sw;
            cv1_reg  <= cv;
            neg1_reg <= neg;
        end
    end

    assign prod_next = {1'b0, mul_reg} + (hi_reg ? {1'b0, cw1_reg, 32'd0} : 64'd0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            sw2_reg  <= sw1_reg;
            cv2_reg  <= cv1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // Load divider; quotient at or above 2^36 is flagged here.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= {3'd0, prod_reg[63:36]};
            low_reg[0]  <= prod_reg[35:0];
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= {3'd0, prod_reg[63:36]} >= sw2_reg;
            swp_reg[0]  <= sw2_reg;
            cvp_reg[0]  <= cv2_reg;
            negp_reg[0] <= neg2_reg;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_div
        logic [31:0] t0;
        logic [31:0] t1;
        logic [30:0] r0;
        logic [30:0] rem_next;
        logic        b0;
        logic        b1;

        always_comb
        begin
            t0       = {rem_reg[k], low_reg[k][35]};
            b0       = t0 >= {1'b0, swp_reg[k]};
            r0       = b0 ? 31'(t0 - {1'b0, swp_reg[k]}) : t0[30:0];
            t1       = {r0, low_reg[k][34]};
            b1       = t1 >= {1'b0, swp_reg[k]};
            rem_next = b1 ? 31'(t1 - {1'b0, swp_reg[k]}) : t1[30:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                low_reg[k+1]  <= {low_reg[k][33:0], 2'b00};
                quo_reg[k+1]  <= {quo_reg[k][33:0], b0, b1};
                ovf_reg[k+1]  <= ovf_reg[k];
                swp_reg[k+1]  <= swp_reg[k];
                cvp_reg[k+1]  <= cvp_reg[k];
                negp_reg[k+1] <= negp_reg[k];
            end
        end
    end

    // Floor toward minus infinity for negative offsets, then ceil.
    always_comb
    begin
        rnz  = rem_reg[N] != '0;
        qbig = ovf_reg[N] || (quo_reg[N] > srvr_pkg::EDGE_LIMIT);
        if (negp_reg[N])
            fl_next = 38'(cvp_reg[N]) - signed'({2'b00, quo_reg[N]}) - 38'(rnz);
        else
            fl_next = 38'(cvp_reg[N]) + signed'({2'b00, quo_reg[N]});
        ce_next = fl_next + 38'(rnz);
        ok_next = !qbig && (fl_next >= srvr_pkg::I32_MIN) && (ce_next <= srvr_pkg::I32_MAX);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fl_reg <= fl_next;
            ce_reg <= ce_next;
            ok_reg <= ok_next;
        end
    end

    assign fl = fl_reg;
    assign ce = ce_reg;
    assign ok = ok_reg;

    `SRVR_ASSERT_IMP(a_ceil_step, ok_reg, (ce_reg == fl_reg) || (ce_reg == fl_reg + 38'sd1))
    `SRVR_ASSERT_IMP(a_ok_in_range, ok_reg, fl_reg >= srvr_pkg::I32_MIN)
    `SRVR_ASSERT_IMP(a_rem_below_div, en && !ovf_reg[N] && (swp_reg[N] != '0), rem_reg[N] < swp_reg[N])

endmodule

>>> rtl/core/scissor_rect_viewport_remap.sv
// Items pass the input, offset, edge-unit and result registers to rsp_*.
// Throughput: one item per cycle; every stage advances together unless the
//   output register holds an item that is stalled.
// Reset (rst_n low, asynchronous): clear all valid bits; data registers keep
//   whatever they hold.
`include "scissor_rect_viewport_remap_defines.svh"

module scissor_rect_viewport_remap
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  srvr_pkg::req_t req_item,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output srvr_pkg::rsp_t rsp_item
);

    localparam int L = srvr_pkg::EDGE_LAT;

    // Global advance: the pipe moves whenever the output slot can be vacated.
    logic en;

    // Input capture stage.
    logic           in_vld_reg;
    srvr_pkg::req_t in_reg;

    // Offset stage: edge offsets from the source viewport, split to
    // magnitude and sign for the unsigned divider.
    logic               d_vld_next;
    logic        [32:0] mag_next [0:3];
    logic               neg_next [0:3];
    logic        [32:0] mag_reg  [0:3];
    logic               neg_reg  [0:3];
    logic signed [31:0] cv_reg   [0:3];
    logic        [30:0] cw_reg   [0:3];
    logic        [30:0] sw_reg   [0:3];
    logic signed [33:0] d_next   [0:3];
    srvr_pkg::meta_t    meta_next;

    // Item fields and valid bits that ride alongside the edge units.
    srvr_pkg::meta_t    meta_reg [0:L];
    logic               vld_reg  [0:L];

    logic signed [37:0] fl [0:3];
    logic signed [37:0] ce [0:3];
    logic               eok [0:3];

    // Result stage.
    logic               rsp_vld_reg;
    srvr_pkg::rsp_t     rsp_reg;
    srvr_pkg::rsp_t     rsp_next;
    logic signed [37:0] wd;
    logic signed [37:0] ht;
    logic               ok_all;

    assign en        = !rsp_vld_reg || !rsp_stall;
    assign req_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (en)
            in_vld_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            in_reg <= req_item;
    end

    // Edge order: left, bottom, right, top.
    always_comb
    begin
        d_next[0] = 34'(in_reg.scissor_x) - 34'(in_reg.src_view_x);
        d_next[1] = 34'(in_reg.scissor_y) - 34'(in_reg.src_view_y);
        d_next[2] = 34'(in_reg.scissor_x) + 34'(in_reg.scissor_w) - 34'(in_reg.src_view_x);
        d_next[3] = 34'(in_reg.scissor_y) + 34'(in_reg.scissor_h) - 34'(in_reg.src_view_y);
        for (int i = 0; i < 4; i++)
        begin
            neg_next[i] = d_next[i][33];
            mag_next[i] = neg_next[i] ? 33'(-d_next[i]) : d_next[i][32:0];
        end
        meta_next.sx     = in_reg.scissor_x;
        meta_next.sy     = in_reg.scissor_y;
        meta_next.sw     = in_reg.scissor_w;
        meta_next.sh     = in_reg.scissor_h;
        // Reject non-positive viewport sizes and negative scissor sizes.
        meta_next.pre_ok = (in_reg.src_view_w > 0) && (in_reg.src_view_h > 0)
                        && (in_reg.cap_view_w > 0) && (in_reg.cap_view_h > 0)
                        && !in_reg.scissor_w[31] && !in_reg.scissor_h[31];
        d_vld_next       = in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mag_reg[i] <= mag_next[i];
                neg_reg[i] <= neg_next[i];
            end
            cv_reg[0] <= in_reg.cap_view_x;
            cv_reg[1] <= in_reg.cap_view_y;
            cv_reg[2] <= in_reg.cap_view_x;
            cv_reg[3] <= in_reg.cap_view_y;
            cw_reg[0] <= in_reg.cap_view_w[30:0];
            cw_reg[1] <= in_reg.cap_view_h[30:0];
            cw_reg[2] <= in_reg.cap_view_w[30:0];
            cw_reg[3] <= in_reg.cap_view_h[30:0];
            sw_reg[0] <= in_reg.src_view_w[30:0];
            sw_reg[1] <= in_reg.src_view_h[30:0];
            sw_reg[2] <= in_reg.src_view_w[30:0];
            sw_reg[3] <= in_reg.src_view_h[30:0];
            meta_reg[0] <= meta_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= d_vld_next;
    end

    // Hold item fields and valid bits level with the edge units.
    for (genvar k = 0; k < L; k++)
    begin : g_meta
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                meta_reg[k+1] <= meta_reg[k];
        end
    end

    // One exact floor/ceil unit per edge.
    for (genvar e = 0; e < 4; e++)
    begin : g_edge
        srvr_edge_map u_edge
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .cv    (cv_reg[e]),
            .mag   (mag_reg[e]),
            .neg   (neg_reg[e]),
            .cw    (cw_reg[e]),
            .sw    (sw_reg[e]),
            .fl    (fl[e]),
            .ce    (ce[e]),
            .ok    (eok[e])
        );
    end

    // Resolve sizes, range checks and the pass-through on rejection.
    always_comb
    begin
        wd     = ce[2] - fl[0];
        ht     = ce[3] - fl[1];
        ok_all = meta_reg[L].pre_ok && eok[0] && eok[1] && eok[2] && eok[3]
              && (wd <= srvr_pkg::I32_MAX) && (ht <= srvr_pkg::I32_MAX);
        if (ok_all)
        begin
            rsp_next.out_x    = fl[0][31:0];
            rsp_next.out_y    = fl[1][31:0];
            rsp_next.out_w    = (meta_reg[L].sw == 0) ? 32'sd0 : wd[31:0];
            rsp_next.out_h    = (meta_reg[L].sh == 0) ? 32'sd0 : ht[31:0];
            rsp_next.accepted = 1'b1;
            rsp_next.changed  = (rsp_next.out_x != meta_reg[L].sx)
                             || (rsp_next.out_y != meta_reg[L].sy)
                             || (rsp_next.out_w != meta_reg[L].sw)
                             || (rsp_next.out_h != meta_reg[L].sh);
        end
        else
        begin
            rsp_next.out_x    = meta_reg[L].sx;
            rsp_next.out_y    = meta_reg[L].sy;
            rsp_next.out_w    = meta_reg[L].sw;
            rsp_next.out_h    = meta_reg[L].sh;
            rsp_next.accepted = 1'b0;
            rsp_next.changed  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_vld_reg <= 1'b0;
        else if (en)
            rsp_vld_reg <= vld_reg[L];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp_item  = rsp_reg;

    `SRVR_ASSERT_IMP(a_changed_needs_ok, rsp_vld_reg && rsp_reg.changed, rsp_reg.accepted)
    `SRVR_ASSERT_IMP(a_width_sign, rsp_vld_reg && rsp_reg.accepted, !rsp_reg.out_w[31])
    `SRVR_ASSERT_IMP(a_height_sign, rsp_vld_reg && rsp_reg.accepted, !rsp_reg.out_h[31])
    `SRVR_ASSERT_NEVER(a_stall_loses, $past(rsp_vld_reg && rsp_stall) && !rsp_vld_reg)

endmodule
